// ===== rtl/mhdt_pkg.sv =====
package mhdt_pkg;

  // Default sizes of the stores.
  localparam int DEF_MAX_STRINGS = 64;
  localparam int DEF_MAX_LENGTH  = 1024;
  localparam int DEF_SYMBOL_BITS = 5;

  // Port field widths.
  localparam int FUNC_W      = 3;
  localparam int SIDX_IN_W   = 6;
  localparam int POS_IN_W    = 10;
  localparam int SYM_IN_W    = 5;
  localparam int DIST_OUT_W  = 11;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 11;
  localparam int STRINGS_W   = 7;
  localparam int LENGTH_W    = 11;

  // Register reset values, before clamping to the store sizes.
  localparam int STRINGS_RESET = 64;
  localparam int LENGTH_RESET  = 1024;

  // Operation codes.
  localparam logic [FUNC_W-1:0] FUNC_LOAD_REF = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_SET_CAND = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_UPD_CAND = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_QUERY    = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_READ     = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_STRINGS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LENGTH  = 2'd1;

  typedef struct packed {
    logic [FUNC_W-1:0]    func;
    logic [SIDX_IN_W-1:0] string_index;
    logic [POS_IN_W-1:0]  position;
    logic [SYM_IN_W-1:0]  symbol;
  } item_t;

  typedef struct packed {
    logic [DIST_OUT_W-1:0] max_distance;
    logic [SIDX_IN_W-1:0]  farthest_string;
    logic [SYM_IN_W-1:0]   read_symbol;
    logic                  cost_valid;
  } result_t;

  // Address width for a store of the given depth, never below one bit.
  function automatic int addr_bits(int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

// ===== rtl/mhdt_ram.sv =====
module mhdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [mhdt_pkg::addr_bits(DEPTH)-1:0]  waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [mhdt_pkg::addr_bits(DEPTH)-1:0]  raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/max_hamming_distance_tracker.sv =====
// Max Hamming distance tracker. The block stores reference strings, one
// candidate string and the distance from the candidate to every reference
// string in use, and reports the largest distance with the first string that
// has it. A transaction is accepted when start is high and busy is low; its
// single result appears for exactly one cycle with done high and cannot be
// held off, so the receiver must take it in that cycle. A reference load, a
// candidate write, a query on current distances and an unused code pass from
// acceptance through the decode state to the result, a candidate read also
// through a read state. An incremental update reads the old candidate symbol,
// then sweeps the reference and distance memories, each giving one string
// per cycle, and writes the candidate. When the distances are stale (after
// reset, an in-range load or candidate write, or a defined register write),
// a query or update first recomputes all of them, the reference and candidate
// memories delivering one symbol pair per cycle. A new transaction may be
// accepted in the cycle that shows the previous result. Registers are
// written through the cfg channel only while the block is idle. No clearing
// pass runs after reset: the stores are valid only where written.
module max_hamming_distance_tracker #(
  parameter int MAX_STRINGS = mhdt_pkg::DEF_MAX_STRINGS,
  parameter int MAX_LENGTH  = mhdt_pkg::DEF_MAX_LENGTH,
  parameter int SYMBOL_BITS = mhdt_pkg::DEF_SYMBOL_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  mhdt_pkg::item_t                     item,
  output logic                                done,
  output mhdt_pkg::result_t                   result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mhdt_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [mhdt_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import mhdt_pkg::*;

  // Index widths of the strings and positions, and of a distance.
  localparam int SW        = addr_bits(MAX_STRINGS);
  localparam int POS_W     = addr_bits(MAX_LENGTH);
  localparam int DW        = $clog2(MAX_LENGTH + 1);
  localparam int REF_DEPTH = MAX_STRINGS * MAX_LENGTH;
  localparam int REF_AW    = addr_bits(REF_DEPTH);

  // The reset values of the registers, stored as last index in use.
  localparam int NS_RESET_EFF = (STRINGS_RESET < MAX_STRINGS) ? STRINGS_RESET : MAX_STRINGS;
  localparam int LEN_RESET_EFF = (LENGTH_RESET < MAX_LENGTH) ? LENGTH_RESET : MAX_LENGTH;
  localparam logic [SW-1:0]    NS_LAST_RESET  = SW'(NS_RESET_EFF - 1);
  localparam logic [POS_W-1:0] LEN_LAST_RESET = POS_W'(LEN_RESET_EFF - 1);

  // Sequencer states.
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DECODE   = 4'd1;
  localparam logic [3:0] S_READ     = 4'd2;
  localparam logic [3:0] S_RECOMP   = 4'd3;
  localparam logic [3:0] S_UPD_RD   = 4'd4;
  localparam logic [3:0] S_UPD_OLD  = 4'd5;
  localparam logic [3:0] S_UPD      = 4'd6;
  localparam logic [3:0] S_CAND_WR  = 4'd7;
  localparam logic [3:0] S_RESULT   = 4'd8;

  function automatic logic [REF_AW-1:0] ref_addr(logic [SW-1:0] s, logic [POS_W-1:0] p);
    return REF_AW'(32'(s) * MAX_LENGTH + 32'(p));
  endfunction

  logic [3:0] state;

  // Registers: the last string index and last position in use.
  logic [SW-1:0]    ns_last;
  logic [POS_W-1:0] len_last;

  // The accepted transaction.
  logic [FUNC_W-1:0]      func_q;
  logic [SW-1:0]          sidx_q;
  logic [POS_W-1:0]       pos_q;
  logic [SYMBOL_BITS-1:0] sym_q;
  logic                   sidx_ok;
  logic                   pos_ok;

  // Tracked cost and the report of a candidate read.
  logic [DW-1:0]          largest;
  logic [SW-1:0]          largest_idx;
  logic                   stale;
  logic [SYMBOL_BITS-1:0] rd_sym;
  logic [SYMBOL_BITS-1:0] old_sym;

  // Read issue counters and the compare stage behind the memories.
  logic [SW-1:0]    s_cnt;
  logic [POS_W-1:0] p_cnt;
  logic             issuing;
  logic             p1_valid;
  logic [SW-1:0]    p1_s;
  logic             p1_first;
  logic             p1_last;
  logic             p1_final;
  logic [DW-1:0]    acc;

  // Memory ports.
  logic                   ref_we;
  logic [REF_AW-1:0]      ref_waddr;
  logic [REF_AW-1:0]      ref_raddr;
  logic [SYMBOL_BITS-1:0] ref_rdata;
  logic                   cand_we;
  logic [POS_W-1:0]       cand_raddr;
  logic [SYMBOL_BITS-1:0] cand_rdata;
  logic                   dist_we;
  logic [DW-1:0]          dist_wdata;
  logic [DW-1:0]          dist_rdata;

  logic             accept;
  logic [DW-1:0]    acc_new;
  logic [DW-1:0]    upd_new;
  logic             track_en;
  logic [SW-1:0]    ns_last_next;
  logic [POS_W-1:0] len_last_next;
  logic             pos_in_len;

  assign busy      = (state != S_IDLE) && (state != S_RESULT);
  assign accept    = start && !busy;
  assign cfg_ready = !busy;
  assign done      = (state == S_RESULT);

  assign result.max_distance    = DIST_OUT_W'(largest);
  assign result.farthest_string = SIDX_IN_W'(largest_idx);
  assign result.read_symbol     = SYM_IN_W'(rd_sym);
  assign result.cost_valid      = !stale;

  assign pos_in_len = (pos_q <= len_last);

  // Clamp a written register value into the range the stores support.
  always_comb begin
    if (cfg_data[STRINGS_W-1:0] == '0) begin
      ns_last_next = '0;
    end else if (32'(cfg_data[STRINGS_W-1:0]) > MAX_STRINGS) begin
      ns_last_next = SW'(MAX_STRINGS - 1);
    end else begin
      ns_last_next = SW'(32'(cfg_data[STRINGS_W-1:0]) - 1);
    end
    if (cfg_data[LENGTH_W-1:0] == '0) begin
      len_last_next = '0;
    end else if (32'(cfg_data[LENGTH_W-1:0]) > MAX_LENGTH) begin
      len_last_next = POS_W'(MAX_LENGTH - 1);
    end else begin
      len_last_next = POS_W'(32'(cfg_data[LENGTH_W-1:0]) - 1);
    end
  end

  // Compare stage: one symbol pair of a recompute, or one string of an update.
  always_comb begin
    acc_new = (p1_first ? '0 : acc) + DW'(ref_rdata != cand_rdata);
    upd_new = dist_rdata;
    if ((ref_rdata != old_sym) && (dist_rdata != '0)) begin
      upd_new = upd_new - DW'(1);
    end
    if (ref_rdata != sym_q) begin
      upd_new = upd_new + DW'(1);
    end
  end

  always_comb begin
    dist_we    = p1_valid && (((state == S_RECOMP) && p1_last) || (state == S_UPD));
    dist_wdata = (state == S_RECOMP) ? acc_new : upd_new;
    track_en   = dist_we && ((p1_s == '0) || (dist_wdata > largest));
  end

  // Memory addressing. Each distance entry is read once per update and
  // written back in the following cycle, so a read never meets a pending write to it.
  always_comb begin
    ref_we     = (state == S_DECODE) && (func_q == FUNC_LOAD_REF) && sidx_ok && pos_ok;
    ref_waddr  = ref_addr(sidx_q, pos_q);
    ref_raddr  = ref_addr(s_cnt, (state == S_RECOMP) ? p_cnt : pos_q);
    cand_we    = ((state == S_DECODE) && (func_q == FUNC_SET_CAND) && pos_ok)
                 || (state == S_CAND_WR);
    cand_raddr = (state == S_RECOMP) ? p_cnt : pos_q;
  end

  mhdt_ram #(.WIDTH(SYMBOL_BITS), .DEPTH(REF_DEPTH)) u_ref_ram (
    .clk   (clk),
    .we    (ref_we),
    .waddr (ref_waddr),
    .wdata (sym_q),
    .raddr (ref_raddr),
    .rdata (ref_rdata)
  );

  mhdt_ram #(.WIDTH(SYMBOL_BITS), .DEPTH(MAX_LENGTH)) u_cand_ram (
    .clk   (clk),
    .we    (cand_we),
    .waddr (pos_q),
    .wdata (sym_q),
    .raddr (cand_raddr),
    .rdata (cand_rdata)
  );

  mhdt_ram #(.WIDTH(DW), .DEPTH(MAX_STRINGS)) u_dist_ram (
    .clk   (clk),
    .we    (dist_we),
    .waddr (p1_s),
    .wdata (dist_wdata),
    .raddr (s_cnt),
    .rdata (dist_rdata)
  );

  // Payload of the accepted transaction.
  always_ff @(posedge clk) begin
    if (accept) begin
      func_q  <= item.func;
      sidx_q  <= SW'(item.string_index);
      pos_q   <= POS_W'(item.position);
      sym_q   <= SYMBOL_BITS'(item.symbol);
      sidx_ok <= (32'(item.string_index) < MAX_STRINGS);
      pos_ok  <= (32'(item.position) < MAX_LENGTH);
    end
  end

  // Sequencer, counters and tracked state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      ns_last     <= NS_LAST_RESET;
      len_last    <= LEN_LAST_RESET;
      largest     <= '0;
      largest_idx <= '0;
      stale       <= 1'b1;
      rd_sym      <= '0;
      issuing     <= 1'b0;
      p1_valid    <= 1'b0;
      s_cnt       <= '0;
      p_cnt       <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_STRINGS: begin
            ns_last <= ns_last_next;
            stale   <= 1'b1;
          end
          CFG_LENGTH: begin
            len_last <= len_last_next;
            stale    <= 1'b1;
          end
          default: begin
          end
        endcase
      end

      if (track_en) begin
        largest     <= dist_wdata;
        largest_idx <= p1_s;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_DECODE;
          end
        end

        S_DECODE: begin
          rd_sym <= '0;
          state  <= S_RESULT;
          case (func_q)
            FUNC_LOAD_REF: begin
              if (sidx_ok && pos_ok) begin
                stale <= 1'b1;
              end
            end
            FUNC_SET_CAND: begin
              if (pos_ok) begin
                stale <= 1'b1;
              end
            end
            FUNC_UPD_CAND, FUNC_QUERY: begin
              if ((func_q == FUNC_QUERY) || pos_ok) begin
                if (stale) begin
                  state       <= S_RECOMP;
                  s_cnt       <= '0;
                  p_cnt       <= '0;
                  issuing     <= 1'b1;
                  largest     <= '0;
                  largest_idx <= '0;
                end else if (func_q == FUNC_UPD_CAND) begin
                  state <= S_UPD_RD;
                end
              end
            end
            FUNC_READ: begin
              if (pos_ok) begin
                state <= S_READ;
              end
            end
            default: begin
            end
          endcase
        end

        S_READ: begin
          rd_sym <= cand_rdata;
          state  <= S_RESULT;
        end

        S_RECOMP: begin
          p1_valid <= issuing;
          p1_s     <= s_cnt;
          p1_first <= (p_cnt == '0);
          p1_last  <= (p_cnt == len_last);
          p1_final <= (p_cnt == len_last) && (s_cnt == ns_last);
          if (issuing) begin
            if (p_cnt == len_last) begin
              p_cnt <= '0;
              if (s_cnt == ns_last) begin
                issuing <= 1'b0;
              end else begin
                s_cnt <= s_cnt + SW'(1);
              end
            end else begin
              p_cnt <= p_cnt + POS_W'(1);
            end
          end
          if (p1_valid) begin
            acc <= acc_new;
            if (p1_final) begin
              stale    <= 1'b0;
              p1_valid <= 1'b0;
              state    <= (func_q == FUNC_UPD_CAND) ? S_UPD_RD : S_RESULT;
            end
          end
        end

        S_UPD_RD: begin
          // The candidate read at the position is issued in this state.
          state <= pos_in_len ? S_UPD_OLD : S_CAND_WR;
        end

        S_UPD_OLD: begin
          old_sym <= cand_rdata;
          s_cnt   <= '0;
          issuing <= 1'b1;
          state   <= S_UPD;
        end

        S_UPD: begin
          p1_valid <= issuing;
          p1_s     <= s_cnt;
          p1_first <= 1'b0;
          p1_last  <= 1'b1;
          p1_final <= (s_cnt == ns_last);
          if (issuing) begin
            if (s_cnt == ns_last) begin
              issuing <= 1'b0;
            end else begin
              s_cnt <= s_cnt + SW'(1);
            end
          end
          if (p1_valid && p1_final) begin
            p1_valid <= 1'b0;
            state    <= S_CAND_WR;
          end
        end

        S_CAND_WR: begin
          state <= S_RESULT;
        end

        S_RESULT: begin
          state <= accept ? S_DECODE : S_IDLE;
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The compare stage only carries data while a memory sweep is running.
  assert property (@(posedge clk) disable iff (rst)
    p1_valid |-> ((state == S_RECOMP) || (state == S_UPD)))
    else $error("compare stage valid outside a sweep");

  // A finished recompute leaves the distances current.
  assert property (@(posedge clk) disable iff (rst)
    ((state == S_RECOMP) && p1_valid && p1_final) |=> !stale)
    else $error("distances still stale after recompute");

  // Every accepted transaction is decoded in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_DECODE))
    else $error("accepted transaction not decoded");

  // A result strobe lasts a single cycle.
  assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

endmodule
